// ===== design/bplm_pkg.sv =====
// ============================================================================
// bplm_pkg
// Shared types and constants for the buffer pool LRU manager.
// ============================================================================
package bplm_pkg;

   localparam int FRAMES_DEF = 32;
   localparam int FRAME_W    = 5;
   localparam int PAGE_W     = 32;
   localparam int PIN_W      = 16;
   localparam int AGE_W      = 5;
   localparam int MODE_W     = 2;
   localparam int STATUS_W   = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_FIX   = 2'd0,
      MODE_UNFIX = 2'd1,
      MODE_DIRTY = 2'd2,
      MODE_FLUSH = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NO_VICTIM = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_PIN_OVF   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MATCH,
      S_DECIDE,
      S_SCAN,
      S_VICTIM,
      S_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_MATCH,
      OP_EXEC,
      OP_SCAN,
      OP_VICTIM,
      OP_FLUSH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     hit;
      logic     fresh_ok;
      logic     any_dirty;
      logic     rsp_free;
      logic     idx_last;
      logic     flush_hit;
      logic     flush_more;
   } stat_type;

endpackage

// ===== design/bplm_if.sv =====
// ============================================================================
// bplm_if
// Request and response channels of the buffer pool LRU manager.
// ============================================================================
interface bplm_req_if;
   logic                             valid;
   logic                             ready;
   logic [bplm_pkg::MODE_W-1:0]      mode;
   logic [bplm_pkg::PAGE_W-1:0]      page_number;
   logic [bplm_pkg::FRAME_W-1:0]     frame_index;

   modport source (output valid, mode, page_number, frame_index, input ready);
   modport sink   (input valid, mode, page_number, frame_index, output ready);
endinterface

interface bplm_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [bplm_pkg::FRAME_W-1:0]     frame_out;
   logic                             was_hit;
   logic                             read_needed;
   logic                             write_back;
   logic [bplm_pkg::PAGE_W-1:0]      write_page;
   logic [bplm_pkg::STATUS_W-1:0]    status;
   logic                             last;

   modport source (output valid, frame_out, was_hit, read_needed, write_back,
                   write_page, status, last, input ready);
   modport sink   (input valid, frame_out, was_hit, read_needed, write_back,
                   write_page, status, last, output ready);
endinterface

// ===== design/bplm_ctrl.sv =====
// ============================================================================
// bplm_ctrl
// Sequencer that steps the datapath through match, decide, scan, victim and flush.
// ============================================================================
module bplm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  bplm_pkg::stat_type  stat,
   output bplm_pkg::cmd_type   cmd
);

   bplm_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bplm_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = bplm_pkg::OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         bplm_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bplm_pkg::OP_CAPTURE;
               state_in = bplm_pkg::S_MATCH;
            end
         end
         bplm_pkg::S_MATCH: begin
            cmd.op   = bplm_pkg::OP_MATCH;
            state_in = bplm_pkg::S_DECIDE;
         end
         bplm_pkg::S_DECIDE: begin
            if (stat.mode == bplm_pkg::MODE_FLUSH && stat.any_dirty) begin
               state_in = bplm_pkg::S_FLUSH;
            end else if (stat.mode == bplm_pkg::MODE_FIX && !stat.hit
                         && !stat.fresh_ok) begin
               state_in = bplm_pkg::S_SCAN;
            end else if (stat.rsp_free) begin
               cmd.op   = bplm_pkg::OP_EXEC;
               state_in = bplm_pkg::S_IDLE;
            end
         end
         bplm_pkg::S_SCAN: begin
            cmd.op = bplm_pkg::OP_SCAN;
            if (stat.idx_last) begin
               state_in = bplm_pkg::S_VICTIM;
            end
         end
         bplm_pkg::S_VICTIM: begin
            if (stat.rsp_free) begin
               cmd.op   = bplm_pkg::OP_VICTIM;
               state_in = bplm_pkg::S_IDLE;
            end
         end
         bplm_pkg::S_FLUSH: begin
            if (!stat.flush_hit) begin
               cmd.op = bplm_pkg::OP_FLUSH;
            end else if (stat.rsp_free) begin
               cmd.op = bplm_pkg::OP_FLUSH;
               if (!stat.flush_more) begin
                  state_in = bplm_pkg::S_IDLE;
               end
            end
         end
         default: state_in = bplm_pkg::S_IDLE;
      endcase
   end

endmodule

// ===== design/bplm_dpath.sv =====
// ============================================================================
// bplm_dpath
// Frame table, associative match, victim scan, LRU ranks and result register.
// ============================================================================
module bplm_dpath #(
   parameter int FRAMES = bplm_pkg::FRAMES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bplm_pkg::cmd_type                 cmd,
   output bplm_pkg::stat_type                stat,
   input  logic [bplm_pkg::MODE_W-1:0]       req_mode,
   input  logic [bplm_pkg::PAGE_W-1:0]       req_page_number,
   input  logic [bplm_pkg::FRAME_W-1:0]      req_frame_index,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [bplm_pkg::FRAME_W-1:0]      rsp_frame_out,
   output logic                              rsp_was_hit,
   output logic                              rsp_read_needed,
   output logic                              rsp_write_back,
   output logic [bplm_pkg::PAGE_W-1:0]       rsp_write_page,
   output logic [bplm_pkg::STATUS_W-1:0]     rsp_status,
   output logic                              rsp_last
);

   localparam int IW = $clog2(FRAMES);
   localparam int CW = $clog2(FRAMES + 1);
   localparam logic [bplm_pkg::PIN_W-1:0] PIN_MAX = '1;

   logic [bplm_pkg::PAGE_W-1:0] page_ff [FRAMES];
   logic [bplm_pkg::PIN_W-1:0]  pins_ff [FRAMES];
   logic [bplm_pkg::AGE_W-1:0]  age_ff  [FRAMES];
   logic [FRAMES-1:0]           dirty_ff;
   logic [CW-1:0]               untouched_ff;

   bplm_pkg::mode_type          mode_ff;
   logic [bplm_pkg::PAGE_W-1:0] req_page_ff;
   logic [bplm_pkg::FRAME_W-1:0] fi_ff;
   logic [FRAMES-1:0]           hit_vec_ff;
   logic [IW-1:0]               idx_ff;
   logic [IW-1:0]               best_idx_ff;
   logic [bplm_pkg::AGE_W-1:0]  best_age_ff;
   logic                        best_valid_ff;
   logic                        rsp_valid_ff;

   logic [FRAMES-1:0] in_use;
   logic [FRAMES-1:0] above;
   logic [IW-1:0]     hit_idx;
   logic              hit_any;
   logic [IW-1:0]     alloc_idx;
   logic [IW-1:0]     fi_idx;
   logic              fi_ok;
   logic              hit_ovf;
   logic              rsp_free;
   logic              flush_hit;

   // Result next values.
   logic                          ld;
   logic [bplm_pkg::FRAME_W-1:0]  r_frame;
   logic                          r_hit, r_rd, r_wb, r_last;
   logic [bplm_pkg::PAGE_W-1:0]   r_wpage;
   bplm_pkg::status_type          r_status;

   // Frame table actions.
   logic          prom_do, inc_all, fill_do, pin_inc, pin_dec, dirty_set;
   logic [IW-1:0] prom_idx, fill_idx;

   always_comb begin
      for (int g = 0; g < FRAMES; g++) begin
         in_use[g] = (CW'(g) >= untouched_ff);
         above[g]  = (IW'(g) > idx_ff);
      end
      hit_idx = '0;
      for (int g = FRAMES - 1; g >= 0; g--) begin
         if (hit_vec_ff[g]) begin
            hit_idx = IW'(g);
         end
      end
   end

   assign hit_any   = |hit_vec_ff;
   assign alloc_idx = IW'(untouched_ff - CW'(1));
   assign fi_idx    = fi_ff[IW-1:0];
   assign fi_ok     = ({1'b0, fi_ff} < (bplm_pkg::FRAME_W + 1)'(FRAMES)) && in_use[fi_idx];
   assign hit_ovf   = (pins_ff[hit_idx] == PIN_MAX);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign flush_hit = in_use[idx_ff] && dirty_ff[idx_ff];

   assign stat.mode       = mode_ff;
   assign stat.hit        = hit_any;
   assign stat.fresh_ok   = (untouched_ff != '0);
   assign stat.any_dirty  = |(in_use & dirty_ff);
   assign stat.rsp_free   = rsp_free;
   assign stat.idx_last   = (idx_ff == IW'(FRAMES - 1));
   assign stat.flush_hit  = flush_hit;
   assign stat.flush_more = |(in_use & dirty_ff & above);

   always_comb begin
      ld = 1'b0; r_frame = '0; r_hit = 1'b0; r_rd = 1'b0; r_wb = 1'b0;
      r_wpage = '0; r_status = bplm_pkg::ST_OK; r_last = 1'b1;
      prom_do = 1'b0; prom_idx = hit_idx; inc_all = 1'b0;
      fill_do = 1'b0; fill_idx = alloc_idx;
      pin_inc = 1'b0; pin_dec = 1'b0; dirty_set = 1'b0;
      case (cmd.op)
         bplm_pkg::OP_EXEC: begin
            ld = 1'b1;
            unique case (mode_ff)
               bplm_pkg::MODE_FIX: begin
                  if (hit_any) begin
                     r_frame = bplm_pkg::FRAME_W'(hit_idx);
                     r_hit   = 1'b1;
                     if (hit_ovf) begin
                        r_status = bplm_pkg::ST_PIN_OVF;
                     end else begin
                        pin_inc = 1'b1;
                        prom_do = 1'b1;
                     end
                  end else begin
                     r_frame = bplm_pkg::FRAME_W'(alloc_idx);
                     r_rd    = 1'b1;
                     inc_all = 1'b1;
                     fill_do = 1'b1;
                  end
               end
               bplm_pkg::MODE_UNFIX: begin
                  if (hit_any) begin
                     r_frame = bplm_pkg::FRAME_W'(hit_idx);
                     pin_dec = 1'b1;
                  end else begin
                     r_status = bplm_pkg::ST_NOT_FOUND;
                  end
               end
               bplm_pkg::MODE_DIRTY: begin
                  r_frame = fi_ff;
                  if (fi_ok) begin
                     dirty_set = 1'b1;
                  end else begin
                     r_status = bplm_pkg::ST_NOT_FOUND;
                  end
               end
               bplm_pkg::MODE_FLUSH: begin
                  r_frame = '0;
               end
               default: ;
            endcase
         end
         bplm_pkg::OP_VICTIM: begin
            ld = 1'b1;
            if (best_valid_ff) begin
               r_frame  = bplm_pkg::FRAME_W'(best_idx_ff);
               r_rd     = 1'b1;
               r_wb     = dirty_ff[best_idx_ff];
               r_wpage  = dirty_ff[best_idx_ff] ? page_ff[best_idx_ff] : '0;
               prom_do  = 1'b1;
               prom_idx = best_idx_ff;
               fill_do  = 1'b1;
               fill_idx = best_idx_ff;
            end else begin
               r_status = bplm_pkg::ST_NO_VICTIM;
            end
         end
         bplm_pkg::OP_FLUSH: begin
            if (flush_hit) begin
               ld      = 1'b1;
               r_frame = bplm_pkg::FRAME_W'(idx_ff);
               r_wb    = 1'b1;
               r_wpage = page_ff[idx_ff];
               r_last  = !stat.flush_more;
            end
         end
         default: ;
      endcase
   end

   // Payload registers: pages, ranks, item, match vector, scan best, result.
   always_ff @(posedge clock) begin
      if (cmd.op == bplm_pkg::OP_CAPTURE) begin
         mode_ff     <= bplm_pkg::mode_type'(req_mode);
         req_page_ff <= req_page_number;
         fi_ff       <= req_frame_index;
      end
      if (cmd.op == bplm_pkg::OP_MATCH) begin
         for (int g = 0; g < FRAMES; g++) begin
            hit_vec_ff[g] <= in_use[g] && (page_ff[g] == req_page_ff);
         end
      end
      if (cmd.op == bplm_pkg::OP_SCAN && in_use[idx_ff] && pins_ff[idx_ff] == '0
          && (!best_valid_ff || age_ff[idx_ff] > best_age_ff)) begin
         best_idx_ff <= idx_ff;
         best_age_ff <= age_ff[idx_ff];
      end
      for (int g = 0; g < FRAMES; g++) begin
         if (inc_all && in_use[g]) begin
            age_ff[g] <= age_ff[g] + bplm_pkg::AGE_W'(1);
         end
         if (prom_do && IW'(g) != prom_idx && in_use[g] && age_ff[g] < age_ff[prom_idx]) begin
            age_ff[g] <= age_ff[g] + bplm_pkg::AGE_W'(1);
         end
      end
      if (prom_do) begin
         age_ff[prom_idx] <= '0;
      end
      if (fill_do) begin
         // A victim refill already cleared its rank through the promotion.
         if (!prom_do) begin
            age_ff[fill_idx] <= '0;
         end
         page_ff[fill_idx] <= req_page_ff;
      end
      if (ld) begin
         rsp_frame_out   <= r_frame;
         rsp_was_hit     <= r_hit;
         rsp_read_needed <= r_rd;
         rsp_write_back  <= r_wb;
         rsp_write_page  <= r_wpage;
         rsp_status      <= r_status;
         rsp_last        <= r_last;
      end
   end

   // Control registers: pins, dirty marks, fill count, scan index, result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int g = 0; g < FRAMES; g++) begin
            pins_ff[g] <= '0;
         end
         dirty_ff      <= '0;
         untouched_ff  <= CW'(FRAMES);
         idx_ff        <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.op == bplm_pkg::OP_MATCH) begin
            idx_ff        <= '0;
            best_valid_ff <= 1'b0;
         end
         if (cmd.op == bplm_pkg::OP_SCAN) begin
            idx_ff <= idx_ff + IW'(1);
            if (in_use[idx_ff] && pins_ff[idx_ff] == '0) begin
               best_valid_ff <= 1'b1;
            end
         end
         if (cmd.op == bplm_pkg::OP_FLUSH) begin
            idx_ff <= idx_ff + IW'(1);
         end
         if (pin_inc) begin
            pins_ff[hit_idx] <= pins_ff[hit_idx] + bplm_pkg::PIN_W'(1);
         end
         if (pin_dec && pins_ff[hit_idx] != '0) begin
            pins_ff[hit_idx] <= pins_ff[hit_idx] - bplm_pkg::PIN_W'(1);
         end
         if (dirty_set) begin
            dirty_ff[fi_idx] <= 1'b1;
         end
         if (fill_do) begin
            pins_ff[fill_idx]  <= bplm_pkg::PIN_W'(1);
            dirty_ff[fill_idx] <= 1'b0;
         end
         if (inc_all) begin
            untouched_ff <= untouched_ff - CW'(1);
         end
         if (ld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // The fill count never grows past the number of frames.
   a_untouched_range: assert property (@(posedge clock) disable iff (reset)
      untouched_ff <= CW'(FRAMES))
      else $error("untouched count out of range");

   // Reset leaves every frame untouched.
   a_reset_fill: assert property (@(posedge clock)
      reset |=> untouched_ff == CW'(FRAMES))
      else $error("untouched count not restored by reset");

   // A missing victim is only reported once every frame is in use.
   a_no_victim: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status == bplm_pkg::ST_NO_VICTIM |-> untouched_ff == '0)
      else $error("no-victim reported with untouched frames");

   // A read request never goes with a hit.
   a_read_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_read_needed |-> !rsp_was_hit)
      else $error("read requested on a hit");

endmodule

// ===== design/buffer_pool_lru_manager.sv =====
// ============================================================================
// buffer_pool_lru_manager
// Page frame manager with pin counts, dirty marks and LRU replacement.
// ============================================================================
// Usage: requests come in on req_chan (mode, page_number, frame_index) with a
// valid/ready handshake; each accepted word yields one response word on
// rsp_chan, except flush, which yields one word per dirty frame in rising
// frame order with last set on the final one (a single all-zero word with
// last set when nothing is dirty).
// Sequence: a word is captured, matched and decided; fix hit, fix with an
// untouched frame, unfix and set-dirty load the response register from the
// decide step. A fix miss with every frame in use walks the frames one per
// cycle to find the least recent unpinned one, then loads the victim. Flush
// steps one frame per cycle from frame 0 up to the last dirty frame, holding
// at a dirty frame until the response register is free.
// One request at a time: req_chan.ready is high only while the sequencer is
// idle, so the next request is taken only after the previous one has loaded
// its response. Reset clears pin counts, dirty marks and the response valid
// flag and marks all frames untouched. A stalled receiver holds the response
// word in its register; the block can still accept the next request and run
// it up to the point where it needs to load a new response.
module buffer_pool_lru_manager #(
   parameter int FRAMES = bplm_pkg::FRAMES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bplm_req_if.sink   req_chan,
   bplm_rsp_if.source rsp_chan
);

   bplm_pkg::cmd_type  cmd;
   bplm_pkg::stat_type stat;

   // The sequencer decides which step the datapath performs each cycle.
   bplm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the frame table and the response register.
   bplm_dpath #(
      .FRAMES (FRAMES)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_mode        (req_chan.mode),
      .req_page_number (req_chan.page_number),
      .req_frame_index (req_chan.frame_index),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_frame_out   (rsp_chan.frame_out),
      .rsp_was_hit     (rsp_chan.was_hit),
      .rsp_read_needed (rsp_chan.read_needed),
      .rsp_write_back  (rsp_chan.write_back),
      .rsp_write_page  (rsp_chan.write_page),
      .rsp_status      (rsp_chan.status),
      .rsp_last        (rsp_chan.last)
   );

endmodule

// ===== tb/buffer_pool_lru_manager_test.sv =====
// ============================================================================
// buffer_pool_lru_manager_test
// Self-checking testbench for the buffer pool LRU manager. A behavioral model
// of the frame table predicts every response word from the accepted request
// words, and a checker compares each response field by field in order.
// ============================================================================
module buffer_pool_lru_manager_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NFRAMES    = bplm_pkg::FRAMES_DEF;
   localparam int FRAME_W    = bplm_pkg::FRAME_W;
   localparam int PAGE_W     = bplm_pkg::PAGE_W;
   localparam int PIN_W      = bplm_pkg::PIN_W;
   localparam int AGE_W      = bplm_pkg::AGE_W;
   localparam int IDLE_LIMIT = 3000;
   localparam int MAX_SHOWN  = 10;

   // One expected response word.
   typedef struct {
      logic [FRAME_W-1:0]   frame;
      logic                 hit;
      logic                 read_needed;
      logic                 write_back;
      logic [PAGE_W-1:0]    write_page;
      bplm_pkg::status_type status;
      logic                 last;
   } pool_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bplm_req_if req_chan ();
   bplm_rsp_if rsp_chan ();

   buffer_pool_lru_manager #(.FRAMES(NFRAMES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #4 clock = ~clock;

   // Model of the frame table, kept in step with the accepted request words.
   logic [PAGE_W-1:0] pool_page  [NFRAMES];
   logic [PIN_W-1:0]  pool_pins  [NFRAMES];
   logic              pool_dirty [NFRAMES];
   logic [AGE_W-1:0]  pool_age   [NFRAMES];
   int                fresh_left;

   pool_answer_type pending_answers[$];

   int  mismatches   = 0;
   int  idle_cycles  = 0;
   int  rsp_gap      = 0;
   int  hold_request = 0;
   int  hold_left    = 0;
   bit  quiet        = 1'b0;

   logic [PAGE_W-1:0] page_set[40];

   // Short gaps are the rule; now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 9) < 8)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // A frame is in use once it has left the untouched region at the bottom.
   function automatic bit resident(int f);
      return f >= fresh_left;
   endfunction

   function automatic int find_page(logic [PAGE_W-1:0] p);
      for (int f = 0; f < NFRAMES; f++)
         if (resident(f) && pool_page[f] == p)
            return f;
      return -1;
   endfunction

   // Make frame f most recent; frames more recent than it age by one.
   function automatic void make_recent(int f);
      logic [AGE_W-1:0] a;
      a = pool_age[f];
      for (int g = 0; g < NFRAMES; g++)
         if (g != f && resident(g) && pool_age[g] < a)
            pool_age[g] = pool_age[g] + 1'b1;
      pool_age[f] = '0;
   endfunction

   function automatic void push_answer(int frame, logic hit, logic rd, logic wb,
                                       logic [PAGE_W-1:0] wp,
                                       bplm_pkg::status_type st, logic last);
      pool_answer_type a;
      a.frame       = frame[FRAME_W-1:0];
      a.hit         = hit;
      a.read_needed = rd;
      a.write_back  = wb;
      a.write_page  = wp;
      a.status      = st;
      a.last        = last;
      pending_answers = {pending_answers, a};
   endfunction

   function automatic void predict_fix(logic [PAGE_W-1:0] p);
      int h;
      int best;
      logic wb;
      logic [PAGE_W-1:0] wp;
      h = find_page(p);
      if (h >= 0) begin
         if (pool_pins[h] == '1) begin
            push_answer(h, 1'b1, 1'b0, 1'b0, '0, bplm_pkg::ST_PIN_OVF, 1'b1);
         end else begin
            pool_pins[h]++;
            make_recent(h);
            push_answer(h, 1'b1, 1'b0, 1'b0, '0, bplm_pkg::ST_OK, 1'b1);
         end
      end else if (fresh_left > 0) begin
         // Take the highest untouched frame; everything in use ages by one.
         for (int g = 0; g < NFRAMES; g++)
            if (resident(g))
               pool_age[g] = pool_age[g] + 1'b1;
         fresh_left--;
         pool_age[fresh_left]   = '0;
         pool_page[fresh_left]  = p;
         pool_pins[fresh_left]  = PIN_W'(1);
         pool_dirty[fresh_left] = 1'b0;
         push_answer(fresh_left, 1'b0, 1'b1, 1'b0, '0, bplm_pkg::ST_OK, 1'b1);
      end else begin
         // Least recent unpinned frame; the lowest index wins a tie.
         best = -1;
         for (int g = 0; g < NFRAMES; g++)
            if (pool_pins[g] == 0 && (best < 0 || pool_age[g] > pool_age[best]))
               best = g;
         if (best < 0) begin
            push_answer(0, 1'b0, 1'b0, 1'b0, '0, bplm_pkg::ST_NO_VICTIM, 1'b1);
         end else begin
            wb = pool_dirty[best];
            wp = wb ? pool_page[best] : '0;
            make_recent(best);
            pool_page[best]  = p;
            pool_pins[best]  = PIN_W'(1);
            pool_dirty[best] = 1'b0;
            push_answer(best, 1'b0, 1'b1, wb, wp, bplm_pkg::ST_OK, 1'b1);
         end
      end
   endfunction

   function automatic void predict_word(bplm_pkg::mode_type m, logic [PAGE_W-1:0] p,
                                        logic [FRAME_W-1:0] fi);
      int h;
      int n;
      int k;
      case (m)
         bplm_pkg::MODE_FIX: begin
            predict_fix(p);
         end
         bplm_pkg::MODE_UNFIX: begin
            h = find_page(p);
            if (h < 0) begin
               push_answer(0, 1'b0, 1'b0, 1'b0, '0, bplm_pkg::ST_NOT_FOUND, 1'b1);
            end else begin
               if (pool_pins[h] != 0)
                  pool_pins[h]--;
               push_answer(h, 1'b0, 1'b0, 1'b0, '0, bplm_pkg::ST_OK, 1'b1);
            end
         end
         bplm_pkg::MODE_DIRTY: begin
            if (!resident(int'(fi))) begin
               push_answer(int'(fi), 1'b0, 1'b0, 1'b0, '0, bplm_pkg::ST_NOT_FOUND, 1'b1);
            end else begin
               pool_dirty[fi] = 1'b1;
               push_answer(int'(fi), 1'b0, 1'b0, 1'b0, '0, bplm_pkg::ST_OK, 1'b1);
            end
         end
         default: begin
            // Flush reports dirty frames in rising order and keeps the marks.
            n = 0;
            for (int f = 0; f < NFRAMES; f++)
               if (resident(f) && pool_dirty[f])
                  n++;
            if (n == 0) begin
               push_answer(0, 1'b0, 1'b0, 1'b0, '0, bplm_pkg::ST_OK, 1'b1);
            end else begin
               k = 0;
               for (int f = 0; f < NFRAMES; f++)
                  if (resident(f) && pool_dirty[f]) begin
                     k++;
                     push_answer(f, 1'b0, 1'b0, 1'b1, pool_page[f], bplm_pkg::ST_OK,
                                 k == n);
                  end
            end
         end
      endcase
   endfunction

   // Offers one request word and waits for it to be taken. The valid line is
   // lowered only when a gap follows, so back-to-back words keep it high.
   task automatic send_word(bplm_pkg::mode_type m, logic [PAGE_W-1:0] p,
                            logic [FRAME_W-1:0] fi);
      int gap;
      req_chan.valid       <= 1'b1;
      req_chan.mode        <= m;
      req_chan.page_number <= p;
      req_chan.frame_index <= fi;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      predict_word(m, p, fi);
      gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      while (pending_answers.size() != 0)
         @(posedge clock);
   endtask

   // Empty table: unknown unfix, bad frames, empty flush, page extremes,
   // hits, unfix of an unpinned page and a flush with marks set.
   task automatic test_directed();
      send_word(bplm_pkg::MODE_UNFIX, 32'h0000_0000, 5'd0);
      send_word(bplm_pkg::MODE_DIRTY, 32'h0, 5'd31);
      send_word(bplm_pkg::MODE_DIRTY, 32'h0, 5'd0);
      send_word(bplm_pkg::MODE_FLUSH, 32'h0, 5'd0);
      send_word(bplm_pkg::MODE_FIX, 32'h0000_0000, 5'd0);
      send_word(bplm_pkg::MODE_FIX, 32'hFFFF_FFFF, 5'd31);
      send_word(bplm_pkg::MODE_FIX, 32'h0000_0000, 5'd0);
      send_word(bplm_pkg::MODE_DIRTY, 32'h0, 5'd31);
      send_word(bplm_pkg::MODE_DIRTY, 32'hFFFF_FFFF, 5'd30);
      send_word(bplm_pkg::MODE_UNFIX, 32'h0000_0000, 5'd0);
      send_word(bplm_pkg::MODE_UNFIX, 32'h0000_0000, 5'd0);
      send_word(bplm_pkg::MODE_UNFIX, 32'h0000_0000, 5'd0);
      send_word(bplm_pkg::MODE_UNFIX, 32'h1234_5678, 5'd7);
      send_word(bplm_pkg::MODE_FLUSH, 32'h0, 5'd0);
      send_word(bplm_pkg::MODE_UNFIX, 32'hFFFF_FFFF, 5'd0);
   endtask

   // Fill every frame with a pinned page; one more miss finds no victim.
   task automatic test_no_victim();
      for (int i = 0; i < NFRAMES; i++)
         send_word(bplm_pkg::MODE_FIX, 32'h100 + i, 5'(i));
      send_word(bplm_pkg::MODE_FIX, 32'hDEAD_BEEF, 5'd0);
   endtask

   // Release the pins of a few frames and unfix pages that were evicted.
   task automatic test_release();
      for (int i = 0; i < 8; i++)
         send_word(bplm_pkg::MODE_UNFIX, 32'h100 + i, 5'(i));
      send_word(bplm_pkg::MODE_UNFIX, 32'h0000_0000, 5'd0);
      send_word(bplm_pkg::MODE_UNFIX, 32'hFFFF_FFFF, 5'd0);
   endtask

   // Misses on a full table walk the LRU order; dirty victims write back.
   task automatic test_victims();
      for (int i = 0; i < 8; i++)
         send_word(bplm_pkg::MODE_DIRTY, 32'h0, 5'($urandom_range(0, NFRAMES - 1)));
      for (int i = 0; i < 6; i++) begin
         send_word(bplm_pkg::MODE_FIX, 32'h2000 + i, 5'd0);
         send_word(bplm_pkg::MODE_UNFIX, 32'h2000 + i, 5'd0);
      end
      send_word(bplm_pkg::MODE_FLUSH, 32'h0, 5'd0);
   endtask

   // The receiver holds off while requests keep coming, then the sender
   // pauses until every response is in.
   task automatic test_backpressure();
      hold_request = 150;
      for (int i = 0; i < 8; i++)
         send_word(i % 2 ? bplm_pkg::MODE_UNFIX : bplm_pkg::MODE_FIX, page_set[i], 5'(i));
      send_word(bplm_pkg::MODE_FLUSH, 32'h0, 5'd0);
      wait_drained();
   endtask

   // Random traffic over a small page set so hits and misses both occur,
   // with some fully random pages and the odd flush.
   task automatic test_random();
      int r;
      logic [PAGE_W-1:0] p;
      for (int i = 0; i < 20; i++) begin
         r = $urandom_range(0, 99);
         p = ($urandom_range(0, 9) == 0) ? $urandom : page_set[$urandom_range(0, 39)];
         if (r < 45)
            send_word(bplm_pkg::MODE_FIX, p, 5'($urandom));
         else if (r < 77)
            send_word(bplm_pkg::MODE_UNFIX, p, 5'($urandom));
         else if (r < 94)
            send_word(bplm_pkg::MODE_DIRTY, $urandom, 5'($urandom));
         else
            send_word(bplm_pkg::MODE_FLUSH, $urandom, 5'($urandom));
      end
   endtask

   // Response ready: random gaps, or a long hold when a test asks for one.
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0)
            rsp_gap = pick_gap();
      end
   end

   // Each accepted response word is matched against the oldest prediction.
   always @(posedge clock) begin
      pool_answer_type e;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("%0t: response word with none expected", $realtime);
         end else begin
            e = pending_answers.pop_front();
            if (rsp_chan.frame_out !== e.frame || rsp_chan.was_hit !== e.hit ||
                rsp_chan.read_needed !== e.read_needed ||
                rsp_chan.write_back !== e.write_back ||
                rsp_chan.write_page !== e.write_page ||
                rsp_chan.status !== e.status || rsp_chan.last !== e.last) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN) begin
                  $display("%0t: expected frame=%0d hit=%b rd=%b wb=%b wp=%h st=%0d last=%b",
                           $realtime, e.frame, e.hit, e.read_needed, e.write_back,
                           e.write_page, e.status, e.last);
                  $display("%0t: actual   frame=%0d hit=%b rd=%b wb=%b wp=%h st=%0d last=%b",
                           $realtime, rsp_chan.frame_out, rsp_chan.was_hit,
                           rsp_chan.read_needed, rsp_chan.write_back,
                           rsp_chan.write_page, rsp_chan.status, rsp_chan.last);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which neither channel moves a word.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      req_chan.valid       = 1'b0;
      req_chan.mode        = bplm_pkg::MODE_FIX;
      req_chan.page_number = '0;
      req_chan.frame_index = '0;
      rsp_chan.ready       = 1'b0;
      for (int f = 0; f < NFRAMES; f++) begin
         pool_page[f]  = '0;
         pool_pins[f]  = '0;
         pool_dirty[f] = 1'b0;
         pool_age[f]   = '0;
      end
      fresh_left = NFRAMES;
      page_set[0] = 32'h0000_0000;
      page_set[1] = 32'hFFFF_FFFF;
      page_set[2] = 32'hAAAA_AAAA;
      page_set[3] = 32'h5555_5555;
      for (int i = 4; i < 40; i++)
         page_set[i] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_no_victim();
      test_release();
      test_victims();
      test_backpressure();
      test_random();

      req_chan.valid <= 1'b0;
      wait_drained();
      repeat (50) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bplm_pkg.sv
design/bplm_if.sv
design/bplm_ctrl.sv
design/bplm_dpath.sv
design/buffer_pool_lru_manager.sv
tb/buffer_pool_lru_manager_test.sv
